>>> rtl/core/dxt_pkg.sv
// dxt_pkg: shared types, constants and divide helpers for the texture block decoder
// no dependencies; imported by every module under rtl/core
`default_nettype none

package dxt_pkg;

  // image geometry
  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);    // 13: width/height register
  localparam int POS_W      = $clog2(MAX_DIM);        // 12: pixel coordinate
  localparam int BLK_W      = POS_W - 2;              // 10: block coordinate
  localparam int BCNT_W     = BLK_W + 1;              // 11: block count, holds MAX_DIM/4

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_FORMAT_MODE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // format codes
  localparam logic FMT_DXT1 = 1'b0;
  localparam logic FMT_DXT5 = 1'b1;

  // request payload
  typedef struct packed {
    logic [63:0] color_block;
    logic [63:0] alpha_block;
  } in_t;

  // result payload
  typedef struct packed {
    logic [POS_W-1:0] pix_x;
    logic [POS_W-1:0] pix_y;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             last_of_block;
  } out_t;

  // decoded block handed from front to back
  typedef struct packed {
    logic [3:0][23:0] pal_rgb;   // {red, green, blue} per color index
    logic [7:0][7:0]  alut;      // alpha ramp
    logic [15:0][1:0] cidx;      // color index per pixel
    logic [15:0][2:0] aidx;      // alpha index per pixel
    logic [BLK_W-1:0] col;
    logic [BLK_W-1:0] row;
    logic [1:0]       vcm;       // last visible column inside the block
    logic [1:0]       vrm;       // last visible row inside the block
    logic             mode;
    logic             punch;     // three-color block, index 3 is transparent black
  } ent_t;

  // n / 3 for n < 768, reciprocal multiply
  function automatic logic [7:0] div3(input logic [9:0] n);
    logic [19:0] prod;
    prod = 20'(n) * 20'd683;
    return prod[18:11];
  endfunction

  // n / 5 for n < 1280
  function automatic logic [7:0] div5(input logic [10:0] n);
    logic [21:0] prod;
    prod = 22'(n) * 22'd1639;
    return prod[20:13];
  endfunction

  // n / 7 for n < 1792
  function automatic logic [7:0] div7(input logic [10:0] n);
    logic [22:0] prod;
    prod = 23'(n) * 23'd2341;
    return prod[21:14];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dxt_front.sv
// dxt_front: config registers, block position counter, request stage and palette build
// depends on dxt_pkg; feeds dxt_fifo
`default_nettype none

module dxt_front
  import dxt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire in_t                   in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [DIM_W-1:0]      cfg_data,
  output logic                       wr_en,
  output ent_t                       wr_data,
  input  wire logic                  fifo_full
);

  logic             format_mode;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [BLK_W-1:0] block_col;
  logic [BLK_W-1:0] block_row;

  // request stage
  logic             stage_valid;
  logic             stage_clip;
  in_t              stage_blk;
  logic [BLK_W-1:0] stage_col;
  logic [BLK_W-1:0] stage_row;
  logic [1:0]       stage_vcm;
  logic [1:0]       stage_vrm;
  logic             stage_mode;

  logic              accept;
  logic              leave;
  logic [DIM_W-1:0]  wc;
  logic [DIM_W-1:0]  hc;
  logic [BCNT_W-1:0] cols;
  logic [BCNT_W-1:0] rows;
  logic [BCNT_W-1:0] col_p1;
  logic [BCNT_W-1:0] row_p1;
  logic [DIM_W-1:0]  xbase;
  logic [DIM_W-1:0]  ybase;
  logic [DIM_W-1:0]  remx;
  logic [DIM_W-1:0]  remy;
  logic              clip_x;
  logic              clip_y;
  logic [1:0]        vcm;
  logic [1:0]        vrm;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode  <= FMT_DXT1;
      image_width  <= DIM_W'(4);
      image_height <= DIM_W'(4);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FORMAT_MODE:  format_mode  <= cfg_data[0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped image size and block counts
  always_comb begin
    if (image_width == '0) wc = DIM_W'(1);
    else if (image_width > DIM_W'(MAX_DIM)) wc = DIM_W'(MAX_DIM);
    else wc = image_width;
    if (image_height == '0) hc = DIM_W'(1);
    else if (image_height > DIM_W'(MAX_DIM)) hc = DIM_W'(MAX_DIM);
    else hc = image_height;
    cols   = BCNT_W'((wc + DIM_W'(3)) >> 2);
    rows   = BCNT_W'((hc + DIM_W'(3)) >> 2);
    col_p1 = BCNT_W'(block_col) + BCNT_W'(1);
    row_p1 = BCNT_W'(block_row) + BCNT_W'(1);
  end

  // visible extent of the block at the current position
  always_comb begin
    xbase  = {1'b0, block_col, 2'b00};
    ybase  = {1'b0, block_row, 2'b00};
    clip_x = xbase >= wc;
    clip_y = ybase >= hc;
    remx   = wc - xbase;
    remy   = hc - ybase;
    vcm    = (remx >= DIM_W'(4)) ? 2'd3 : remx[1:0] - 2'd1;
    vrm    = (remy >= DIM_W'(4)) ? 2'd3 : remy[1:0] - 2'd1;
  end

  // stage handshake; fully clipped blocks drop out without a queue slot
  assign leave  = stage_valid && (stage_clip || !fifo_full);
  assign full   = stage_valid && !stage_clip && fifo_full;
  assign accept = push && !full;
  assign wr_en  = stage_valid && !stage_clip && !fifo_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (leave) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_blk  <= in_data;
      stage_col  <= block_col;
      stage_row  <= block_row;
      stage_vcm  <= vcm;
      stage_vrm  <= vrm;
      stage_clip <= clip_x || clip_y;
      stage_mode <= format_mode;
    end
  end

  // raster block counter
  always_ff @(posedge clk) begin
    if (rst) begin
      block_col <= '0;
      block_row <= '0;
    end else if (accept) begin
      if (col_p1 >= cols) begin
        block_col <= '0;
        block_row <= (row_p1 >= rows) ? '0 : row_p1[BLK_W-1:0];
      end else begin
        block_col <= col_p1[BLK_W-1:0];
      end
    end
  end

  // palette and alpha ramp from the staged block
  logic [15:0]      c0;
  logic [15:0]      c1;
  logic [2:0][7:0]  e0;
  logic [2:0][7:0]  e1;
  logic [2:0][7:0]  p2;
  logic [2:0][7:0]  p3;
  logic [9:0]       s2;
  logic [9:0]       s3;
  logic [8:0]       sh;
  logic             four;
  logic [7:0]       a0;
  logic [7:0]       a1;
  logic [10:0]      n7;
  logic [10:0]      n5;
  logic [7:0][7:0]  alut;

  always_comb begin
    c0   = stage_blk.color_block[15:0];
    c1   = stage_blk.color_block[31:16];
    e0   = {{c0[15:11], 3'b000}, {c0[10:5], 2'b00}, {c0[4:0], 3'b000}};
    e1   = {{c1[15:11], 3'b000}, {c1[10:5], 2'b00}, {c1[4:0], 3'b000}};
    four = (stage_mode == FMT_DXT5) || (c0 > c1);
    s2   = '0;
    s3   = '0;
    sh   = '0;
    for (int ch = 0; ch < 3; ch++) begin
      s2 = {1'b0, e0[ch], 1'b0} + 10'(e1[ch]) + 10'd1;
      s3 = 10'(e0[ch]) + {1'b0, e1[ch], 1'b0} + 10'd1;
      sh = 9'(e0[ch]) + 9'(e1[ch]) + 9'd1;
      if (four) begin
        p2[ch] = div3(s2);
        p3[ch] = div3(s3);
      end else begin
        p2[ch] = sh[8:1];
        p3[ch] = 8'h00;
      end
    end
  end

  always_comb begin
    a0      = stage_blk.alpha_block[7:0];
    a1      = stage_blk.alpha_block[15:8];
    alut[0] = a0;
    alut[1] = a1;
    n7      = '0;
    n5      = '0;
    for (int i = 2; i < 8; i++) begin
      n7 = 11'(8 - i) * 11'(a0) + 11'(i - 1) * 11'(a1) + 11'd3;
      if (i < 6) n5 = 11'(6 - i) * 11'(a0) + 11'(i - 1) * 11'(a1) + 11'd2;
      else n5 = '0;
      if (a0 > a1) alut[i] = div7(n7);
      else if (i < 6) alut[i] = div5(n5);
      else if (i == 6) alut[i] = 8'h00;
      else alut[i] = 8'hFF;
    end
  end

  // queue entry
  always_comb begin
    wr_data.pal_rgb[0] = {e0[2], e0[1], e0[0]};
    wr_data.pal_rgb[1] = {e1[2], e1[1], e1[0]};
    wr_data.pal_rgb[2] = {p2[2], p2[1], p2[0]};
    wr_data.pal_rgb[3] = {p3[2], p3[1], p3[0]};
    wr_data.alut       = alut;
    wr_data.cidx       = stage_blk.color_block[63:32];
    wr_data.aidx       = stage_blk.alpha_block[63:16];
    wr_data.col        = stage_col;
    wr_data.row        = stage_row;
    wr_data.vcm        = stage_vcm;
    wr_data.vrm        = stage_vrm;
    wr_data.mode       = stage_mode;
    wr_data.punch      = !four;
  end

endmodule

`default_nettype wire

>>> rtl/core/dxt_fifo.sv
// dxt_fifo: short queue of decoded blocks between front and back
// depends on dxt_pkg
`default_nettype none

module dxt_fifo
  import dxt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire ent_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output logic      rd_valid,
  output ent_t      rd_data
);

  ent_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full     = count == FIFO_CNT_W'(FIFO_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (rd_en) rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      case ({wr_en, rd_en})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dxt_back.sv
// dxt_back: walks the visible pixels of the head block and holds the result register
// depends on dxt_pkg; reads dxt_fifo
`default_nettype none

module dxt_back
  import dxt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic rd_valid,
  input  wire ent_t rd_data,
  output logic      rd_en,
  output logic      empty,
  input  wire logic pop,
  output out_t      out_data
);

  logic       out_valid;
  logic [1:0] px;
  logic [1:0] py;
  logic       emit;
  logic       blast;
  logic [3:0] p;
  logic [1:0] ci;
  logic [7:0] alpha;
  out_t       pix;

  assign empty = !out_valid;
  assign emit  = rd_valid && (!out_valid || pop);
  assign blast = (px == rd_data.vcm) && (py == rd_data.vrm);
  assign rd_en = emit && blast;
  assign p     = {py, px};
  assign ci    = rd_data.cidx[p];

  // pixel lookup
  always_comb begin
    if (rd_data.mode == FMT_DXT5) alpha = rd_data.alut[rd_data.aidx[p]];
    else if (rd_data.punch && ci == 2'd3) alpha = 8'h00;
    else alpha = 8'hFF;
    pix.pix_x         = {rd_data.col, px};
    pix.pix_y         = {rd_data.row, py};
    pix.red           = rd_data.pal_rgb[ci][23:16];
    pix.green         = rd_data.pal_rgb[ci][15:8];
    pix.blue          = rd_data.pal_rgb[ci][7:0];
    pix.alpha         = alpha;
    pix.last_of_block = blast;
  end

  // pixel position inside the block
  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      py <= '0;
    end else if (emit) begin
      if (blast) begin
        px <= '0;
        py <= '0;
      end else if (px == rd_data.vcm) begin
        px <= '0;
        py <= py + 2'd1;
      end else begin
        px <= px + 2'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= pix;
    end
  end

  // walker sits at the block origin whenever no block waits
  a_idle_origin: assert property (@(posedge clk) disable iff (rst)
    !rd_valid |-> (px == 2'd0 && py == 2'd0))
    else $error("pixel walker off origin with empty queue");

  // walker never leaves the visible part of the head block
  a_in_extent: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (px <= rd_data.vcm && py <= rd_data.vrm))
    else $error("pixel walker outside visible extent");

  // a block retires only on the edge that loads a marked pixel
  a_retire_marked: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (out_valid && out_data.last_of_block))
    else $error("block retired without a marked last pixel");

endmodule

`default_nettype wire

>>> rtl/core/dxt_texture_block_decoder.sv
// dxt_texture_block_decoder: top level, DXT1/DXT5 4x4 block decoder to RGBA pixels
// depends on dxt_pkg, dxt_front, dxt_fifo, dxt_back
//
//   channel   direction  handshake             payload
//   request   in         push / full           in_data  (color_block, alpha_block)
//   result    out        pop / empty           out_data (pix_x, pix_y, rgba, last_of_block)
//   config    in         cfg_we                cfg_addr, cfg_data
//
// A full block gives sixteen pixels, one per cycle from the back walker while the result
// register is empty or popped; an edge block gives only its visible pixels, and a fully
// clipped block gives none and takes no queue slot. After the accept edge the first pixel
// goes through the queue write and then the result register to the result ports. The front
// takes a new request while the back is still emitting; full rises only when the stage and
// the two-entry queue are both occupied.
// rst is synchronous; it clears the registers to format 0 and size 4x4 and the position to 0.
`default_nettype none

module dxt_texture_block_decoder
  import dxt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire in_t                   in_data,
  output logic                       empty,
  input  wire logic                  pop,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [DIM_W-1:0]      cfg_data
);

  logic wr_en;
  ent_t wr_data;
  logic fifo_full;
  logic rd_en;
  logic rd_valid;
  ent_t rd_data;

  // request side
  dxt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .wr_en     (wr_en),
    .wr_data   (wr_data),
    .fifo_full (fifo_full)
  );

  // decoded block queue
  dxt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_data  (wr_data),
    .full     (fifo_full),
    .rd_en    (rd_en),
    .rd_valid (rd_valid),
    .rd_data  (rd_data)
  );

  // result side
  dxt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (rd_valid),
    .rd_data  (rd_data),
    .rd_en    (rd_en),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
